@@ hw/rtl/csg_pkg.sv @@
// ----------------------------------------------------------------------------
// csg_pkg
// Shared types and constants of the charge-sensor gesture classifier.
// ----------------------------------------------------------------------------
package csg_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int STEP_W    = 17;
    localparam int HOLD_W    = 8;
    localparam int DEV_W     = 19;
    localparam int HIST_DEPTH = 3;
    localparam logic signed [DEV_W-1:0] LEVEL_SCALE = 19'sd32760;

    localparam logic [STEP_W-1:0] BIG_STEP_RST     = 17'd54600;
    localparam logic [STEP_W-1:0] SMALL_STEP_RST   = 17'd23400;
    localparam logic [HOLD_W-1:0] HOLD_NONZERO_RST = 8'd20;
    localparam logic [HOLD_W-1:0] HOLD_ZERO_RST    = 8'd25;
    localparam logic [HOLD_W-1:0] HOLD_MAX         = 8'd255;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [STEP_W-1:0]          t_step;
    typedef logic [HOLD_W-1:0]          t_hold;
    typedef logic signed [1:0]          t_lvl;
    typedef logic signed [2:0]          t_pend;
    typedef logic signed [3:0]          t_gest;

    localparam t_lvl LVL_NEG  = -2'sd1;
    localparam t_lvl LVL_ZERO = 2'sd0;
    localparam t_lvl LVL_POS  = 2'sd1;

    typedef enum logic [1:0] {
        CFG_BIG_STEP     = 2'd0,
        CFG_SMALL_STEP   = 2'd1,
        CFG_HOLD_NONZERO = 2'd2,
        CFG_HOLD_ZERO    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_step big_step;
        t_step small_step;
        t_hold hold_nonzero;
        t_hold hold_zero;
    } t_cfg;

    // debounced level event from the quantizer to the classifier
    typedef struct packed {
        logic push;
        t_lvl level;
    } t_lvl_evt;

endpackage

@@ hw/rtl/csg_level.sv @@
// ----------------------------------------------------------------------------
// csg_level
// Quantizes a sample into a three-valued level and debounces it with a
// saturating hold counter; holds the previous level and the count.
// ----------------------------------------------------------------------------
module csg_level
    import csg_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  t_sample  i_sample,
    input  t_cfg     i_cfg,
    input  t_lvl     i_hist0,
    output t_lvl_evt o_evt
);

    t_lvl  r_prev, n_prev;
    t_hold r_cnt, n_cnt;

    logic signed [DEV_W-1:0] dev, base, big, small_thr;
    t_lvl  lv;
    t_hold cnt_inc;
    logic  same, push;

    always_comb begin
        priority if (r_prev == LVL_POS) begin
            base = LEVEL_SCALE;
        end else if (r_prev == LVL_NEG) begin
            base = -LEVEL_SCALE;
        end else begin
            base = '0;
        end
        dev       = DEV_W'(i_sample) - base;
        big       = signed'({2'b00, i_cfg.big_step});
        small_thr = signed'({2'b00, i_cfg.small_step});

        // big step checked first, small step moves one level with clamping
        priority if (dev >= big) begin
            lv = LVL_POS;
        end else if (dev >= small_thr) begin
            lv = (r_prev == LVL_POS) ? LVL_POS : r_prev + LVL_POS;
        end else if (dev <= -big) begin
            lv = LVL_NEG;
        end else if (dev <= -small_thr) begin
            lv = (r_prev == LVL_NEG) ? LVL_NEG : r_prev - LVL_POS;
        end else begin
            lv = r_prev;
        end

        same    = (lv == r_prev);
        cnt_inc = (r_cnt == HOLD_MAX) ? r_cnt : r_cnt + 8'd1;
        push    = same && (((lv != LVL_ZERO) && (cnt_inc >= i_cfg.hold_nonzero)
                            && (lv != i_hist0))
                        || ((lv == LVL_ZERO) && (cnt_inc >= i_cfg.hold_zero)));

        n_prev = lv;
        n_cnt  = push ? '0 : (same ? cnt_inc : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= LVL_ZERO;
            r_cnt  <= '0;
        end else if (i_en) begin
            r_prev <= n_prev;
            r_cnt  <= n_cnt;
        end
    end

    assign o_evt.push  = push;
    assign o_evt.level = lv;

endmodule

@@ hw/rtl/csg_class.sv @@
// ----------------------------------------------------------------------------
// csg_class
// Three-deep level history and the gesture classifier with its pending
// action register; a gesture code is produced on each pushed level.
// ----------------------------------------------------------------------------
module csg_class
    import csg_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  t_lvl_evt i_evt,
    output t_lvl     o_hist0,
    output t_gest    o_gesture
);

    t_lvl  r_hist [HIST_DEPTH];
    t_pend r_pend, n_pend;
    t_lvl  h0, h1, h2;
    t_pend h2x, h2x2;
    t_gest g, pend2;

    always_comb begin
        // history as it stands after the push
        h0    = i_evt.level;
        h1    = r_hist[0];
        h2    = r_hist[1];
        h2x   = 3'(h2);
        h2x2  = h2x <<< 1;
        pend2 = 4'(r_pend) <<< 1;
        g      = '0;
        n_pend = r_pend;
        priority if (h2 == LVL_ZERO && h0 == LVL_ZERO && r_pend == '0) begin
            n_pend = 3'(h1);
        end else if (h1 == LVL_NEG && h2 == LVL_POS) begin
            g      = -4'sd1;
            n_pend = '0;
        end else if (h1 == LVL_POS && h2 == LVL_NEG) begin
            g      = 4'sd1;
            n_pend = '0;
        end else if (h2x == r_pend && h1 == LVL_ZERO && h0 == LVL_ZERO) begin
            g      = pend2;
            n_pend = '0;
        end else if (h2x2 == r_pend && h1 == LVL_ZERO && h0 == LVL_ZERO) begin
            g      = pend2;
            n_pend = '0;
        end else if (3'(h0) == h2x && 3'(h0) == r_pend && r_pend != '0
                     && h1 == LVL_ZERO) begin
            n_pend = r_pend <<< 1;
        end else if (h2 == LVL_ZERO && h0 == LVL_ZERO && r_pend != '0) begin
            n_pend = r_pend;
        end else begin
            n_pend = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                r_hist[i] <= LVL_ZERO;
            end
            r_pend <= '0;
        end else if (i_en && i_evt.push) begin
            r_hist[0] <= h0;
            for (int i = 1; i < HIST_DEPTH; i++) begin
                r_hist[i] <= r_hist[i-1];
            end
            r_pend <= n_pend;
        end
    end

    assign o_hist0   = r_hist[0];
    assign o_gesture = i_evt.push ? g : '0;

endmodule

@@ hw/rtl/charge_sensor_gesture_classifier.sv @@
// ----------------------------------------------------------------------------
// charge_sensor_gesture_classifier
// Quantizes charge-variation samples into levels and classifies gestures.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid/o_in_ready carries one signed sample a beat.
//   Output channel o_out_valid/i_out_ready carries one result a beat:
//   o_gesture (0 none, +/-1 swipe, +/-2 tap, +/-4 double tap) and o_level.
//   Config channel i_cfg_valid/o_cfg_ready writes big_step, small_step,
//   hold_nonzero, hold_zero by index; it is always ready. The user must
//   write it only while no sample is in flight; the block does not enforce it.
//   A sample waits in the input register, where it is quantized
//   and classified, and its result then moves into the output register.
//   One sample per cycle is sustained while the receiver does not stall:
//   level, hold count, history and pending action update together as it moves on.
//   Reset (synchronous, active low) empties both registers, clears all
//   state and loads the default thresholds and hold counts.
//   When the receiver stalls the result waits in the output register and
//   one more sample is held in the input register before o_in_ready drops.
// ----------------------------------------------------------------------------
module charge_sensor_gesture_classifier
    import csg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_sample     i_sample,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_gest       o_gesture,
    output t_lvl        o_level,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);

    t_cfg     r_cfg;
    logic     r_in_vld, r_out_vld;
    t_sample  r_sample;
    t_gest    r_gesture;
    t_lvl     r_level;
    logic     move;
    t_lvl_evt evt;
    t_lvl     hist0;
    t_gest    gesture;

    assign move        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || move;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.big_step     <= BIG_STEP_RST;
            r_cfg.small_step   <= SMALL_STEP_RST;
            r_cfg.hold_nonzero <= HOLD_NONZERO_RST;
            r_cfg.hold_zero    <= HOLD_ZERO_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_BIG_STEP:     r_cfg.big_step     <= i_cfg_data;
                CFG_SMALL_STEP:   r_cfg.small_step   <= i_cfg_data;
                CFG_HOLD_NONZERO: r_cfg.hold_nonzero <= i_cfg_data[HOLD_W-1:0];
                CFG_HOLD_ZERO:    r_cfg.hold_zero    <= i_cfg_data[HOLD_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_vld <= 1'b1;
            end else if (move) begin
                r_in_vld <= 1'b0;
            end
            if (move) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_sample <= i_sample;
        end
        if (move) begin
            r_gesture <= gesture;
            r_level   <= evt.level;
        end
    end

    csg_level u_level (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (move),
        .i_sample (r_sample),
        .i_cfg    (r_cfg),
        .i_hist0  (hist0),
        .o_evt    (evt)
    );

    csg_class u_class (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (move),
        .i_evt     (evt),
        .o_hist0   (hist0),
        .o_gesture (gesture)
    );

    assign o_out_valid = r_out_vld;
    assign o_gesture   = r_gesture;
    assign o_level     = r_level;

    // a tap gesture completes only on a zero level
    a_tap_on_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_gesture == 4'sd2 || o_gesture == -4'sd2
                        || o_gesture == 4'sd4 || o_gesture == -4'sd4)
        |-> o_level == LVL_ZERO)
        else $error("tap gesture with nonzero level");

    // a held sample stays in the input register until it moves on
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !move |=> r_in_vld && $stable(r_sample))
        else $error("input register lost a waiting sample");

    // both registers full and the receiver stalled: no new beat taken
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && r_out_vld && !i_out_ready |-> !o_in_ready)
        else $error("input accepted while pipeline is full");

endmodule

@@ tb/sv/gesture_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gesture_checker
// Follows the sample, result and register channels of the gesture classifier,
// predicts the gesture and level of every accepted sample and compares each
// result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module gesture_checker
    import csg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_sample     i_sample,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_gest       i_gesture,
    input  t_lvl        i_level,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_waiting,
    output int          o_gesture_count
);

    typedef struct packed {
        t_gest gesture;
        t_lvl  level;
    } t_result;

    t_cfg    cfg;
    t_lvl    last_level;
    t_hold   run_len;
    t_lvl    history [HIST_DEPTH];
    t_pend   pend_action;
    t_result expected_results [$];
    int      fail_total = 0;
    int      gesture_total = 0;

    assign o_fail_count    = fail_total;
    assign o_gesture_count = gesture_total;

    // gesture decision on a history push, updates the pending action
    function automatic int classify_history();
        int h0, h1, h2, pa, g;
        h0 = int'(history[0]);
        h1 = int'(history[1]);
        h2 = int'(history[2]);
        pa = int'(pend_action);
        g  = 0;
        if (h2 == 0 && h0 == 0 && pa == 0) begin
            pa = h1;
        end else if (h1 == -1 && h2 == 1) begin
            g  = -1;
            pa = 0;
        end else if (h1 == 1 && h2 == -1) begin
            g  = 1;
            pa = 0;
        end else if (h2 == pa && h1 == 0 && h0 == 0) begin
            g  = pa * 2;
            pa = 0;
        end else if (h2 * 2 == pa && h1 == 0 && h0 == 0) begin
            g  = pa * 2;
            pa = 0;
        end else if (h0 == h2 && h0 == pa && pa != 0 && h1 == 0) begin
            pa = pa * 2;
        end else if (!(h2 == 0 && h0 == 0 && pa != 0)) begin
            pa = 0;
        end
        pend_action = t_pend'(pa);
        return g;
    endfunction

    function automatic t_result predict_sample(input t_sample s);
        int      dev, thr_hi, thr_lo, prev, lv, cnt, g;
        logic    push;
        t_result r;
        prev   = int'(last_level);
        thr_hi = int'(cfg.big_step);
        thr_lo = int'(cfg.small_step);
        dev    = int'(s) - prev * int'(LEVEL_SCALE);
        // big thresholds win over small ones, whatever their order
        if (dev >= thr_hi) begin
            lv = 1;
        end else if (dev >= thr_lo) begin
            lv = prev + 1;
        end else if (dev <= -thr_hi) begin
            lv = -1;
        end else if (dev <= -thr_lo) begin
            lv = prev - 1;
        end else begin
            lv = prev;
        end
        if (lv > 1) lv = 1;
        if (lv < -1) lv = -1;

        cnt  = int'(run_len);
        push = 1'b0;
        g    = 0;
        if (lv == prev) begin
            if (cnt < int'(HOLD_MAX)) cnt++;
            // a nonzero level already at the head of the history is not pushed again
            push = (lv != 0 && cnt >= int'(cfg.hold_nonzero) && lv != int'(history[0]))
                || (lv == 0 && cnt >= int'(cfg.hold_zero));
        end else begin
            cnt = 0;
        end
        if (push) begin
            cnt        = 0;
            history[2] = history[1];
            history[1] = history[0];
            history[0] = t_lvl'(lv);
            g          = classify_history();
        end
        run_len    = t_hold'(cnt);
        last_level = t_lvl'(lv);
        r.gesture  = t_gest'(g);
        r.level    = t_lvl'(lv);
        return r;
    endfunction

    always @(posedge i_clk) begin : track
        t_result got, want;
        if (!i_rst_n) begin
            cfg.big_step     = BIG_STEP_RST;
            cfg.small_step   = SMALL_STEP_RST;
            cfg.hold_nonzero = HOLD_NONZERO_RST;
            cfg.hold_zero    = HOLD_ZERO_RST;
            last_level       = LVL_ZERO;
            run_len          = '0;
            pend_action      = '0;
            for (int i = 0; i < HIST_DEPTH; i++) history[i] = LVL_ZERO;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_BIG_STEP:     cfg.big_step     = i_cfg_data[STEP_W-1:0];
                    CFG_SMALL_STEP:   cfg.small_step   = i_cfg_data[STEP_W-1:0];
                    CFG_HOLD_NONZERO: cfg.hold_nonzero = i_cfg_data[HOLD_W-1:0];
                    CFG_HOLD_ZERO:    cfg.hold_zero    = i_cfg_data[HOLD_W-1:0];
                    default: ;
                endcase
            end
            // result beats belong to older samples, so check before predicting
            if (i_out_valid && i_out_ready) begin
                got.gesture = i_gesture;
                got.level   = i_level;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result beat, gesture %0d level %0d",
                             $time, got.gesture, got.level);
                    fail_total++;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        $display("%0t: expected gesture %0d level %0d, got gesture %0d level %0d",
                                 $time, want.gesture, want.level, got.gesture, got.level);
                        fail_total++;
                    end
                    if (want.gesture != 0) gesture_total++;
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(predict_sample(i_sample));
            end
        end
        o_waiting <= expected_results.size();
    end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives charge samples and register writes into the gesture classifier:
// directed corner samples first, then phases of held-level gesture patterns
// mixed with raw noise under changing thresholds and hold counts, with
// random idling on both channels. A checker beside the block scores results.
// ----------------------------------------------------------------------------
module testbench;
    import csg_pkg::*;

    localparam int STALL_LIMIT    = 1000;
    localparam int HOLDOFF_CYCLES = 60;
    localparam int IDLE_PCT       = 38;
    localparam int NOISE_PCT      = 20;
    localparam int SEG_MAX        = 64;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_sample     sample = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_gest       gesture;
    t_lvl        level;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    t_cfg_idx    cfg_index = CFG_BIG_STEP;
    logic [16:0] cfg_data = '0;

    int   fail_count, waiting, gesture_count;
    logic calm = 1'b0;
    logic holdoff_go = 1'b0;
    int   holdoff_left = 0;
    bit   holdoff_done = 1'b0;
    int   samples_sent = 0;
    int   settings = 0;
    int   quiet_cycles = 0;

    always #1 clk = ~clk;

    charge_sensor_gesture_classifier dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_sample    (sample),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_gesture   (gesture),
        .o_level     (level),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    gesture_checker u_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_sample        (sample),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_gesture       (gesture),
        .i_level         (level),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_waiting       (waiting),
        .o_gesture_count (gesture_count)
    );

    // result side: random stalls, plus one long hold-off so the block backs up
    always @(negedge clk) begin
        if (holdoff_go && !holdoff_done) begin
            holdoff_left = HOLDOFF_CYCLES;
            holdoff_done = 1'b1;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles == STALL_LIMIT) begin
                $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
                $display("charge_sensor_gesture_classifier verification failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // entered and left at a falling edge
    task automatic send_sample(input t_sample s);
        int gap;
        gap = 0;
        while (!calm && $urandom_range(99) < IDLE_PCT) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        samples_sent++;
    endtask

    // sample that lands on the wanted level from any previous level
    // under moderate thresholds
    function automatic t_sample level_sample(input int lv);
        if (lv > 0) return t_sample'($urandom_range(32767, 28000));
        if (lv < 0) return t_sample'(-int'($urandom_range(32768, 28000)));
        return t_sample'(int'($urandom_range(8000)) - 4000);
    endfunction

    task automatic drain_and_configure(input int unsigned thr_hi, input int unsigned thr_lo,
                                       input int unsigned hold_nz, input int unsigned hold_z);
        t_cfg_idx    regs [4];
        int unsigned vals [4];
        in_valid <= 1'b0;
        while (waiting != 0) @(negedge clk);
        regs = '{CFG_BIG_STEP, CFG_SMALL_STEP, CFG_HOLD_NONZERO, CFG_HOLD_ZERO};
        vals = '{thr_hi, thr_lo, hold_nz, hold_z};
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i][16:0];
            do @(posedge clk); while (!cfg_ready);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
        settings++;
    endtask

    // held-level segments shaped like swipes and taps, with noise bursts
    // and segments cut short
    task automatic play_gestures(input int budget, input int hold_nz, input int hold_z);
        int start, lv, last, n, base;
        start = samples_sent;
        last  = 0;
        while (samples_sent - start < budget) begin
            if ($urandom_range(99) < NOISE_PCT) begin
                repeat ($urandom_range(6, 1)) send_sample(t_sample'($urandom));
            end else begin
                if (last == 0) begin
                    lv = $urandom_range(1) ? 1 : -1;
                end else if ($urandom_range(99) < 70) begin
                    lv = 0;
                end else begin
                    lv = -last;
                end
                base = (lv == 0) ? hold_z : hold_nz;
                if (base == 0) base = 1;
                if ($urandom_range(99) < 15) begin
                    n = $urandom_range(base + 1, 1);
                end else begin
                    n = base + 1 + $urandom_range(3);
                end
                if (n > SEG_MAX) n = SEG_MAX;
                repeat (n) send_sample(level_sample(lv));
                last = lv;
            end
        end
    endtask

    initial begin : stimulus
        t_sample     plain_pts [7];
        t_sample     clamp_pts [6];
        t_sample     order_pts [6];
        int unsigned thr_hi, thr_lo, hold_nz, hold_z;
        bit          shaped;

        plain_pts = '{16'sd0, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd1,
                      16'sd23400, -16'sd23400};
        clamp_pts = '{16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd0, 16'sd0};
        order_pts = '{16'sd5000, -16'sd5000, 16'sd500, 16'sd0, 16'sd0, 16'sd32767};

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset thresholds, field extremes
        foreach (plain_pts[i]) send_sample(plain_pts[i]);
        // small step 0 pushes past +1/-1, hold counts of 0
        drain_and_configure(60000, 0, 0, 0);
        foreach (clamp_pts[i]) send_sample(clamp_pts[i]);
        // big threshold below small one
        drain_and_configure(1000, 50000, 1, 1);
        foreach (order_pts[i]) send_sample(order_pts[i]);
        // level held at the head of the history is pushed only once
        drain_and_configure(32'(BIG_STEP_RST), 32'(SMALL_STEP_RST), 1, 1);
        repeat (5) send_sample(16'sd32767);

        for (int ph = 0; ph < 10; ph++) begin
            thr_hi  = $urandom_range(60000, 45000);
            thr_lo  = $urandom_range(22000, 12000);
            hold_nz = $urandom_range(5);
            hold_z  = $urandom_range(5);
            shaped  = 1'b1;
            case (ph)
                2: begin
                    thr_hi  = 131071;
                    thr_lo  = 131071;
                    hold_nz = 255;
                    hold_z  = 255;
                    shaped  = 1'b0;
                end
                3: begin
                    thr_hi  = 0;
                    thr_lo  = 0;
                    hold_nz = 1;
                    shaped  = 1'b0;
                end
                4: hold_z = 255;
                5: begin
                    thr_hi  = $urandom_range(131071);
                    thr_lo  = $urandom_range(131071);
                    hold_nz = $urandom_range(255);
                    hold_z  = $urandom_range(255);
                end
                6: begin
                    thr_hi = $urandom_range(20000, 1000);
                    thr_lo = $urandom_range(131071, 30000);
                    shaped = 1'b0;
                end
                default: ;
            endcase
            drain_and_configure(thr_hi, thr_lo, hold_nz, hold_z);
            calm = (ph == 0);
            if (ph == 1) holdoff_go = 1'b1;
            if (shaped) begin
                play_gestures(80, hold_nz, hold_z);
            end else begin
                repeat (80) send_sample(t_sample'($urandom));
            end
            // zero held long enough for the hold count to reach the largest hold_zero setting
            if (ph == 4) repeat (260) send_sample(level_sample(0));
        end

        in_valid <= 1'b0;
        while (waiting != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        $display("covered %0d samples under %0d register settings, extremes included",
                 samples_sent, settings);
        $display("%0d nonzero gesture codes checked, with a long result-side hold-off",
                 gesture_count);
        if (fail_count == 0) begin
            $display("charge_sensor_gesture_classifier verification clean");
        end else begin
            $display("charge_sensor_gesture_classifier verification failed");
        end
        $finish;
    end

endmodule
